// ===== sv/sh9_pkg.sv =====
// shared types, constants and helper functions for the sh9 projection block
package sh9_pkg;

    // signed q30 value for trig, direction and basis terms
    typedef logic signed [32:0] q_t;
    // wider signed q30 for the cordic datapath
    typedef logic signed [33:0] cq_t;

    // one projected texel: nine weights, radiance, end-of-image mark
    typedef struct packed {
        logic [8:0][47:0] wt;
        logic [2:0][31:0] rad;
        logic             last;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam cq_t         PI_C       = 34'sd3373259426;
    localparam cq_t         HALF_PI_C  = 34'sd1686629713;
    localparam cq_t         ONE_C      = 34'sd1073741824;
    localparam cq_t         GAIN_C     = 34'sd652032874;
    localparam q_t          ONE_Q      = 33'sd1073741824;
    // 2*pi^2 in q40
    localparam logic [44:0] BASE_NUM   = 45'd21703489598464;
    localparam int          CORDIC_STEPS = 16;

    localparam q_t C_L0  = 33'sd302897200;
    localparam q_t C_L1  = 33'sd524633476;
    localparam q_t C_L2A = 33'sd1173114482;
    localparam q_t C_L2B = 33'sd338649581;
    localparam q_t C_L2C = 33'sd586557241;

    function automatic cq_t atan_q30(input logic [3:0] i);
        cq_t r;
        case (i)
            4'd0:    r = 34'sd843314856;
            4'd1:    r = 34'sd497837829;
            4'd2:    r = 34'sd263043836;
            4'd3:    r = 34'sd133525158;
            4'd4:    r = 34'sd67021686;
            4'd5:    r = 34'sd33543515;
            4'd6:    r = 34'sd16775850;
            4'd7:    r = 34'sd8388437;
            4'd8:    r = 34'sd4194282;
            4'd9:    r = 34'sd2097149;
            4'd10:   r = 34'sd1048575;
            4'd11:   r = 34'sd524287;
            4'd12:   r = 34'sd262143;
            4'd13:   r = 34'sd131071;
            4'd14:   r = 34'sd65535;
            4'd15:   r = 34'sd32767;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] mag_q(input q_t v);
        q_t n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    function automatic q_t clamp_one(input cq_t v);
        q_t r;
        if (v > ONE_C)
            r = ONE_Q;
        else if (v < -ONE_C)
            r = -ONE_Q;
        else
            r = q_t'(v);
        return r;
    endfunction

endpackage

// ===== sv/sh9_div.sv =====
// restoring divider, one quotient bit per cycle
module sh9_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [44:0] dividend,
    input  logic [24:0] divisor,
    output logic        done,
    output logic [44:0] quotient
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [24:0] rem_reg;
    logic [24:0] dsr_reg;
    logic [44:0] quo_reg;
    logic [25:0] shifted;
    logic [26:0] diff;

    assign shifted = {rem_reg, quo_reg[44]};
    assign diff    = {1'b0, shifted} - {2'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd44)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[26])
                rem_reg <= diff[24:0];
            else
                rem_reg <= shifted[24:0];
            quo_reg <= {quo_reg[43:0], ~diff[26]};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== sv/sh9_fifo.sv =====
// two-entry queue between the front and the back
module sh9_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wdata,
    input  logic                pop,
    output logic [WIDTH-1:0]    rdata,
    output sh9_pkg::fifo_stat_t stat
);
    import sh9_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
endmodule

// ===== sv/sh9_front.sv =====
// front end: texel direction, basis terms and solid-angle weights
module sh9_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [12:0]         w,
    input  logic [11:0]         h,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [11:0]         col,
    input  logic [10:0]         row,
    input  logic [31:0]         red,
    input  logic [31:0]         green,
    input  logic [31:0]         blue,
    input  logic                last_texel,
    output logic                push,
    output sh9_pkg::work_t      wdata,
    input  sh9_pkg::fifo_stat_t stat
);
    import sh9_pkg::*;

    localparam logic [3:0] F_IDLE  = 4'd0;
    localparam logic [3:0] F_DIV_T = 4'd1;
    localparam logic [3:0] F_DIV_P = 4'd2;
    localparam logic [3:0] F_DIV_B = 4'd3;
    localparam logic [3:0] F_COR_T = 4'd4;
    localparam logic [3:0] F_COR_P = 4'd5;
    localparam logic [3:0] F_CALC  = 4'd6;
    localparam logic [3:0] F_WGT   = 4'd7;
    localparam logic [3:0] F_PUSH  = 4'd8;

    logic [3:0]  state_reg;
    logic        div_go_reg;
    logic [4:0]  step_reg;
    logic [3:0]  k_reg;
    logic        ph_reg;
    logic [3:0]  it_reg;

    logic [11:0]       col_reg;
    logic [10:0]       row_reg;
    logic [2:0][31:0]  rad_reg;
    logic              last_reg;
    logic [31:0]       theta_reg;
    logic [31:0]       phi_reg;
    logic [44:0]       base_reg;
    cq_t               cx_reg, cy_reg, cz_reg;
    logic              flip_reg;
    q_t                sin_reg, dy_reg, cp_reg, sp_reg, dx_reg, dz_reg, t_reg, t2_reg;
    q_t                b_reg [9];
    logic [63:0]       acc_reg;
    logic [45:0]       dw_reg;
    logic signed [47:0] wt_reg [9];

    // divider hookup
    logic        div_start;
    logic        div_done;
    logic [44:0] div_dividend;
    logic [24:0] div_divisor;
    logic [44:0] div_quot;
    logic        in_div;

    logic signed [14:0] num;
    logic               num_neg;
    logic [12:0]        num_mag;
    logic [11:0]        col_c;
    logic [10:0]        row_c;
    cq_t                phi_s;
    cq_t                theta_z;
    cq_t                sx, sy, at, nx, ny, nz;
    q_t                 nxc, nyc;

    // shared multiplier
    q_t          op_a, op_b;
    logic [31:0] mul_a, mul_b;
    logic        mneg;
    logic [63:0] prod;
    q_t          qres;
    logic signed [34:0] tri_v;
    logic [77:0] wide;
    logic [47:0] wide_q;
    logic        accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == F_IDLE);
    assign in_div   = (state_reg == F_DIV_T) || (state_reg == F_DIV_P)
                      || (state_reg == F_DIV_B);
    assign div_start = in_div && !div_go_reg;

    // clamp to the image
    assign col_c = ({1'b0, col} >= w) ? 12'(w - 13'd1) : col;
    assign row_c = ({1'b0, row} >= h) ? 11'(h - 12'd1) : row;

    assign num     = $signed({2'b0, col_reg, 1'b1}) - $signed({2'b0, w});
    assign num_neg = num[14];
    assign num_mag = num_neg ? 13'(-num) : 13'(num);

    always_comb
    begin
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            F_DIV_T:
            begin
                div_dividend = 45'(PI_Q30) * 45'({row_reg, 1'b1});
                div_divisor  = 25'({h, 1'b0});
            end
            F_DIV_P:
            begin
                div_dividend = 45'(PI_Q30) * 45'(num_mag);
                div_divisor  = 25'(w);
            end
            F_DIV_B:
            begin
                div_dividend = BASE_NUM;
                div_divisor  = 25'(w) * 25'(h);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    sh9_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // cordic rotation step
    assign theta_z = $signed({2'b0, theta_reg}) - HALF_PI_C;
    assign phi_s   = num_neg ? -$signed({2'b0, phi_reg}) : $signed({2'b0, phi_reg});
    assign sx = cx_reg >>> it_reg;
    assign sy = cy_reg >>> it_reg;
    assign at = atan_q30(it_reg);
    always_comb
    begin
        if (!cz_reg[33])
        begin
            nx = cx_reg - sy;
            ny = cy_reg + sx;
            nz = cz_reg - at;
        end
        else
        begin
            nx = cx_reg + sy;
            ny = cy_reg - sx;
            nz = cz_reg + at;
        end
    end
    assign nxc = clamp_one(nx);
    assign nyc = clamp_one(ny);

    // operand selection for the multiplier
    assign tri_v = 35'(t_reg) + 35'(t_reg) + 35'(t_reg) - 35'(ONE_Q);
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            5'd0:    begin op_a = sin_reg; op_b = cp_reg; end
            5'd1:    begin op_a = sin_reg; op_b = sp_reg; end
            5'd2:    begin op_a = C_L1;    op_b = dy_reg; end
            5'd3:    begin op_a = C_L1;    op_b = dz_reg; end
            5'd4:    begin op_a = C_L1;    op_b = dx_reg; end
            5'd5:    begin op_a = C_L2A;   op_b = dx_reg; end
            5'd6:    begin op_a = t_reg;   op_b = dy_reg; end
            5'd7:    begin op_a = t_reg;   op_b = dz_reg; end
            5'd8:    begin op_a = C_L2A;   op_b = dy_reg; end
            5'd9:    begin op_a = t_reg;   op_b = dz_reg; end
            5'd10:   begin op_a = dz_reg;  op_b = dz_reg; end
            5'd11:   begin op_a = C_L2B;   op_b = q_t'(tri_v); end
            5'd12:   begin op_a = dx_reg;  op_b = dx_reg; end
            5'd13:   begin op_a = dy_reg;  op_b = dy_reg; end
            5'd14:   begin op_a = C_L2C;   op_b = q_t'(34'(t_reg) - 34'(t2_reg)); end
            default: begin op_a = '0;      op_b = '0; end
        endcase
    end

    always_comb
    begin
        mul_a = mag_q(op_a);
        mul_b = mag_q(op_b);
        mneg  = op_a[32] ^ op_b[32];
        if (state_reg == F_WGT)
        begin
            mul_a = mag_q(b_reg[k_reg]);
            mul_b = ph_reg ? 32'(dw_reg[45:32]) : dw_reg[31:0];
            mneg  = b_reg[k_reg][32];
        end
        else if (step_reg == 5'd15)
        begin
            mul_a = mag_q(sin_reg);
            mul_b = base_reg[31:0];
        end
        else if (step_reg == 5'd16)
        begin
            mul_a = mag_q(sin_reg);
            mul_b = 32'(base_reg[44:32]);
        end
    end

    assign prod   = mul_a * mul_b;
    assign qres   = mneg ? -$signed({1'b0, prod[61:30]}) : $signed({1'b0, prod[61:30]});
    assign wide   = 78'(acc_reg) + {prod[45:0], 32'b0};
    assign wide_q = wide[77:30];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            div_go_reg <= 1'b0;
            step_reg   <= '0;
            k_reg      <= '0;
            ph_reg     <= 1'b0;
            it_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                        state_reg <= F_DIV_T;
                end
                F_DIV_T, F_DIV_P, F_DIV_B:
                begin
                    if (div_start)
                        div_go_reg <= 1'b1;
                    if (div_done)
                    begin
                        div_go_reg <= 1'b0;
                        if (state_reg == F_DIV_T)
                            state_reg <= F_DIV_P;
                        else if (state_reg == F_DIV_P)
                            state_reg <= F_DIV_B;
                        else
                        begin
                            state_reg <= F_COR_T;
                            it_reg    <= '0;
                        end
                    end
                end
                F_COR_T:
                begin
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'(CORDIC_STEPS - 1))
                        state_reg <= F_COR_P;
                end
                F_COR_P:
                begin
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= F_CALC;
                        step_reg  <= '0;
                    end
                end
                F_CALC:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd16)
                    begin
                        state_reg <= F_WGT;
                        step_reg  <= '0;
                        k_reg     <= '0;
                        ph_reg    <= 1'b0;
                    end
                end
                F_WGT:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        k_reg <= k_reg + 4'd1;
                        if (k_reg == 4'd8)
                            state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!stat.full)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    col_reg    <= col_c;
                    row_reg    <= row_c;
                    rad_reg[0] <= red;
                    rad_reg[1] <= green;
                    rad_reg[2] <= blue;
                    last_reg   <= last_texel;
                    b_reg[0]   <= C_L0;
                end
            end
            F_DIV_T:
            begin
                if (div_done)
                    theta_reg <= div_quot[31:0];
            end
            F_DIV_P:
            begin
                if (div_done)
                    phi_reg <= div_quot[31:0];
            end
            F_DIV_B:
            begin
                if (div_done)
                begin
                    base_reg <= div_quot;
                    cx_reg   <= GAIN_C;
                    cy_reg   <= '0;
                    cz_reg   <= theta_z;
                end
            end
            F_COR_T:
            begin
                cx_reg <= nx;
                cy_reg <= ny;
                cz_reg <= nz;
                if (it_reg == 4'(CORDIC_STEPS - 1))
                begin
                    sin_reg <= nxc[32] ? '0 : nxc;
                    dy_reg  <= -nyc;
                    // fold phi into the cordic range
                    cx_reg  <= GAIN_C;
                    cy_reg  <= '0;
                    if (phi_s > HALF_PI_C)
                    begin
                        cz_reg   <= phi_s - PI_C;
                        flip_reg <= 1'b1;
                    end
                    else if (phi_s < -HALF_PI_C)
                    begin
                        cz_reg   <= phi_s + PI_C;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        cz_reg   <= phi_s;
                        flip_reg <= 1'b0;
                    end
                end
            end
            F_COR_P:
            begin
                cx_reg <= nx;
                cy_reg <= ny;
                cz_reg <= nz;
                if (it_reg == 4'(CORDIC_STEPS - 1))
                begin
                    cp_reg <= flip_reg ? -nxc : nxc;
                    sp_reg <= flip_reg ? -nyc : nyc;
                end
            end
            F_CALC:
            begin
                case (step_reg)
                    5'd0:    dx_reg   <= qres;
                    5'd1:    dz_reg   <= qres;
                    5'd2:    b_reg[1] <= qres;
                    5'd3:    b_reg[2] <= qres;
                    5'd4:    b_reg[3] <= qres;
                    5'd5:    t_reg    <= qres;
                    5'd6:    b_reg[4] <= qres;
                    5'd7:    b_reg[7] <= qres;
                    5'd8:    t_reg    <= qres;
                    5'd9:    b_reg[5] <= qres;
                    5'd10:   t_reg    <= qres;
                    5'd11:   b_reg[6] <= qres;
                    5'd12:   t_reg    <= qres;
                    5'd13:   t2_reg   <= qres;
                    5'd14:   b_reg[8] <= qres;
                    5'd15:   acc_reg  <= prod;
                    5'd16:   dw_reg   <= wide[75:30];
                    default: acc_reg  <= acc_reg;
                endcase
            end
            F_WGT:
            begin
                if (!ph_reg)
                    acc_reg <= prod;
                else
                    wt_reg[k_reg] <= mneg ? -$signed(wide_q) : $signed(wide_q);
            end
            default:
                acc_reg <= acc_reg;
        endcase
    end

    assign push = (state_reg == F_PUSH) && !stat.full;
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            wdata.wt[i] = wt_reg[i];
        wdata.rad  = rad_reg;
        wdata.last = last_reg;
    end
endmodule

// ===== sv/sh9_back.sv =====
// back end: radiance products, saturating sums and coefficient readout
module sh9_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sh9_pkg::work_t      rdata,
    input  sh9_pkg::fifo_stat_t stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          coeff_index,
    output logic signed [63:0]  coeff_red,
    output logic signed [63:0]  coeff_green,
    output logic signed [63:0]  coeff_blue,
    output logic                last_coeff
);
    import sh9_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_LO   = 3'd1;
    localparam logic [2:0] B_HI   = 3'd2;
    localparam logic [2:0] B_ADD  = 3'd3;
    localparam logic [2:0] B_EMIT = 3'd4;

    logic [2:0]  state_reg;
    logic [3:0]  idx_reg;
    logic        out_valid_reg;
    work_t       cur_reg;
    logic        wneg_reg;
    logic [15:0] whi_reg;
    logic [63:0] plo_reg  [3];
    logic signed [63:0] term_reg [3];
    logic signed [63:0] sum_reg  [3][9];
    logic [3:0]  idx_out_reg;
    logic signed [63:0] out_reg [3];
    logic        last_out_reg;

    logic signed [47:0] wcur;
    logic [47:0] wmag;
    logic        load;
    logic [47:0] phi_p [3];
    logic [79:0] full  [3];
    logic signed [64:0] ssum [3];
    logic signed [63:0] sat  [3];

    assign pop  = (state_reg == B_IDLE) && !stat.empty;
    assign load = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);
    assign wcur = $signed(cur_reg.wt[idx_reg]);
    assign wmag = wcur[47] ? 48'(-wcur) : 48'(wcur);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            phi_p[c] = 48'(whi_reg) * 48'(cur_reg.rad[c]);
            full[c]  = 80'(plo_reg[c]) + {phi_p[c], 32'b0};
            ssum[c]  = 65'(sum_reg[c][idx_reg]) + 65'(term_reg[c]);
            // clip at the signed 64-bit limits
            if (ssum[c][64] != ssum[c][63])
                sat[c] = ssum[c][64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            else
                sat[c] = ssum[c][63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
                for (int k = 0; k < 9; k++)
                    sum_reg[c][k] <= '0;
        end
        else
        begin
            if (out_ready && !load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    idx_reg <= '0;
                    if (pop)
                        state_reg <= B_LO;
                end
                B_LO:
                    state_reg <= B_HI;
                B_HI:
                    state_reg <= B_ADD;
                B_ADD:
                begin
                    for (int c = 0; c < 3; c++)
                        sum_reg[c][idx_reg] <= sat[c];
                    if (idx_reg == 4'd8)
                    begin
                        idx_reg   <= '0;
                        state_reg <= cur_reg.last ? B_EMIT : B_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= B_LO;
                    end
                end
                B_EMIT:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int c = 0; c < 3; c++)
                            sum_reg[c][idx_reg] <= '0;
                        if (idx_reg == 4'd8)
                        begin
                            idx_reg   <= '0;
                            state_reg <= B_IDLE;
                        end
                        else
                            idx_reg <= idx_reg + 4'd1;
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= rdata;
        if (state_reg == B_LO)
        begin
            wneg_reg <= wcur[47];
            whi_reg  <= wmag[47:32];
            for (int c = 0; c < 3; c++)
                plo_reg[c] <= 64'(wmag[31:0]) * 64'(cur_reg.rad[c]);
        end
        if (state_reg == B_HI)
        begin
            for (int c = 0; c < 3; c++)
                term_reg[c] <= wneg_reg ? -$signed(full[c][79:16])
                                        : $signed(full[c][79:16]);
        end
        if (load)
        begin
            idx_out_reg  <= idx_reg;
            last_out_reg <= (idx_reg == 4'd8);
            for (int c = 0; c < 3; c++)
                out_reg[c] <= sum_reg[c][idx_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign coeff_index = idx_out_reg;
    assign coeff_red   = out_reg[0];
    assign coeff_green = out_reg[1];
    assign coeff_blue  = out_reg[2];
    assign last_coeff  = last_out_reg;
endmodule

// ===== sv/sh9_equirect_projection.sv =====
// top level: order-2 spherical harmonics projection of equirectangular texels
// the front carries each texel from accept to its weights reaching the back end,
// the back then accumulates them, and nine coefficient words follow the last texel
// a new texel waits until the front is done; it runs three 45-step serial divisions
// (theta, phi, solid-angle base) on the single shared divider plus two 16-step cordic runs
// reset: width 2048, height 1024, all 27 sums zero, queue and output empty
module sh9_equirect_projection #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration writes
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [12:0]        cfg_wdata,
    // texel input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        col,
    input  logic [10:0]        row,
    input  logic [31:0]        red,
    input  logic [31:0]        green,
    input  logic [31:0]        blue,
    input  logic               last_texel,
    // coefficient output
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         coeff_index,
    output logic signed [63:0] coeff_red,
    output logic signed [63:0] coeff_green,
    output logic signed [63:0] coeff_blue,
    output logic               last_coeff
);
    import sh9_pkg::*;

    logic [12:0] width_reg;
    logic [11:0] height_reg;
    logic [12:0] w_eff;
    logic [11:0] h_eff;

    logic       push;
    logic       pop;
    work_t      push_word;
    work_t      pop_word;
    fifo_stat_t stat;

    // register file, unknown indices dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd2048;
            height_reg <= 12'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata[11:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // a zero size acts as one, an oversize is held at the maximum
    always_comb
    begin
        if (width_reg == 13'd0)
            w_eff = 13'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = 13'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 12'd0)
            h_eff = 12'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = 12'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // front: direction, basis and weights of one texel
    sh9_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .w          (w_eff),
        .h          (h_eff),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .col        (col),
        .row        (row),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_texel (last_texel),
        .push       (push),
        .wdata      (push_word),
        .stat       (stat)
    );

    // short queue so the two halves stall independently
    sh9_fifo #(
        .WIDTH ($bits(work_t))
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_word),
        .pop   (pop),
        .rdata (pop_word),
        .stat  (stat)
    );

    // back: accumulate 27 sums and read them out on the last texel
    sh9_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rdata       (pop_word),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coeff_index (coeff_index),
        .coeff_red   (coeff_red),
        .coeff_green (coeff_green),
        .coeff_blue  (coeff_blue),
        .last_coeff  (last_coeff)
    );

    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
        else $error("push into full queue");

    // the back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
        else $error("pop from empty queue");

    // the end mark sits only on the ninth coefficient
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_coeff == (coeff_index == 4'd8)))
        else $error("last_coeff out of step with coeff_index");

    // a texel keeps the front busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("front took two texels back to back");
endmodule
